// ===== rtl/core/lzsd_pkg.sv =====
// ----------------------------------------------------------------------------
// lzsd_pkg
// shared constants, state codes and controller/datapath interface types
// for the lzss stream decoder
// ----------------------------------------------------------------------------
package lzsd_pkg;

    localparam int WIN_SIZE         = 4096;
    localparam int WIN_AW           = $clog2(WIN_SIZE);
    localparam int MIN_MATCH_OFFSET = 2;
    localparam int CNT_W            = $clog2(256 + MIN_MATCH_OFFSET + 1);
    localparam int LANES            = 8;
    localparam int LANE_CW          = $clog2(LANES + 1);
    localparam int OUT_TDATA_W      = 72;

    typedef enum logic [1:0] {
        PH_TOKEN   = 2'd0,
        PH_DIST_HI = 2'd1,
        PH_DIST_LO = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_READ  = 2'd1,
        ST_WRITE = 2'd2,
        ST_FLUSH = 2'd3
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic rd_issue;
        logic wr_copy;
        logic push;
        logic push_last;
    } ctrl_cmd_t;

    typedef struct packed {
        logic byte_literal;
        logic byte_dist_lo;
        logic pk_full;
        logic out_free;
        logic rem_one;
    } dp_status_t;

endpackage

// ===== rtl/core/lzsd_ctrl.sv =====
// ----------------------------------------------------------------------------
// lzsd_ctrl
// sequencer: takes stream bytes, runs the read/write steps of a match copy
// and hands packed groups to the output register
// ----------------------------------------------------------------------------
module lzsd_ctrl
    import lzsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  dp_status_t  status,
    output ctrl_cmd_t   cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && status.byte_literal)
                begin
                    state_next = ST_FLUSH;
                end
                else if (in_valid && status.byte_dist_lo)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (!status.pk_full || status.out_free)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                state_next = status.rem_one ? ST_FLUSH : ST_READ;
            end
            ST_FLUSH:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ST_READ:
            begin
                if (!status.pk_full || status.out_free)
                begin
                    cmd.rd_issue = 1'b1;
                    cmd.push     = status.pk_full;
                end
            end
            ST_WRITE:
            begin
                cmd.wr_copy = 1'b1;
            end
            ST_FLUSH:
            begin
                cmd.push      = status.out_free;
                cmd.push_last = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/core/lzsd_datapath.sv =====
// ----------------------------------------------------------------------------
// lzsd_datapath
// token decode registers, history window with fill tracking, byte packer
// and output register
// ----------------------------------------------------------------------------
module lzsd_datapath
    import lzsd_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [7:0]              in_byte,
    input  ctrl_cmd_t               cmd,
    output dp_status_t              status,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [8*LANES-1:0]      out_bytes,
    output logic [3:0]              byte_count,
    output logic                    last
);

    logic [7:0]             window_mem [WIN_SIZE];

    phase_t                 phase_reg;
    phase_t                 phase_next;
    logic [8:0]             flag_reg;
    logic [8:0]             flag_next;
    logic [7:0]             len_reg;
    logic [7:0]             dist_hi_reg;
    logic [WIN_AW-1:0]      dist_reg;
    logic [CNT_W-1:0]       rem_reg;
    logic [WIN_AW-1:0]      wp_reg;
    logic                   wrapped_reg;
    logic [7:0]             rd_data_reg;
    logic                   rd_valid_reg;
    logic [8*LANES-1:0]     pk_word_reg;
    logic [8*LANES-1:0]     pk_word_next;
    logic [LANE_CW-1:0]     pk_cnt_reg;
    logic                   out_valid_reg;
    logic [8*LANES-1:0]     out_bytes_reg;
    logic [3:0]             out_cnt_reg;
    logic                   out_last_reg;

    logic                   tok_literal;
    logic                   tok_length;
    logic                   wr_en;
    logic [7:0]             wr_byte;
    logic [WIN_AW-1:0]      rd_addr;
    logic [15:0]            dist_full;
    logic                   out_free;

    // token decode of the byte at the input
    always_comb
    begin
        tok_literal   = 1'b0;
        tok_length    = 1'b0;
        phase_next    = PH_TOKEN;
        flag_next     = flag_reg;
        unique case (phase_reg)
            PH_DIST_HI:
            begin
                phase_next = PH_DIST_LO;
            end
            PH_DIST_LO:
            begin
                phase_next = PH_TOKEN;
            end
            default:
            begin
                if (flag_reg <= 9'd1)
                begin
                    flag_next     = {1'b1, in_byte};
                end
                else
                begin
                    flag_next   = {1'b0, flag_reg[8:1]};
                    tok_literal = flag_reg[0];
                    tok_length  = !flag_reg[0];
                    if (!flag_reg[0])
                    begin
                        phase_next = PH_DIST_HI;
                    end
                end
            end
        endcase
    end

    assign dist_full = {dist_hi_reg, in_byte};
    assign rd_addr   = wp_reg - dist_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign wr_en     = (cmd.accept && tok_literal) || cmd.wr_copy;
    assign wr_byte   = cmd.wr_copy ? (rd_valid_reg ? rd_data_reg : 8'd0) : in_byte;

    assign status.byte_literal = tok_literal;
    assign status.byte_dist_lo = (phase_reg == PH_DIST_LO);
    assign status.pk_full      = (pk_cnt_reg == LANE_CW'(LANES));
    assign status.out_free     = out_free;
    assign status.rem_one      = (rem_reg == CNT_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_TOKEN;
            flag_reg    <= '0;
            len_reg     <= '0;
            dist_hi_reg <= '0;
        end
        else if (cmd.accept)
        begin
            phase_reg <= phase_next;
            if (phase_reg == PH_TOKEN)
            begin
                flag_reg <= flag_next;
            end
            if (tok_length)
            begin
                len_reg <= in_byte;
            end
            if (phase_reg == PH_DIST_HI)
            begin
                dist_hi_reg <= in_byte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
        end
        else if (cmd.accept && phase_reg == PH_DIST_LO)
        begin
            rem_reg <= CNT_W'(len_reg) + CNT_W'(MIN_MATCH_OFFSET + 1);
        end
        else if (cmd.wr_copy)
        begin
            rem_reg <= rem_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && phase_reg == PH_DIST_LO)
        begin
            dist_reg <= dist_full[WIN_AW-1:0];
        end
    end

    // window: entries below the write position, or all once wrapped, hold data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg      <= '0;
            wrapped_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            wp_reg <= wp_reg + WIN_AW'(1);
            if (wp_reg == '1)
            begin
                wrapped_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            window_mem[wp_reg] <= wr_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_issue)
        begin
            rd_data_reg  <= window_mem[rd_addr];
            rd_valid_reg <= wrapped_reg || (rd_addr < wp_reg);
        end
    end

    // byte packer
    always_comb
    begin
        pk_word_next = pk_word_reg;
        for (int i = 0; i < LANES; i++)
        begin
            if (pk_cnt_reg == LANE_CW'(i))
            begin
                pk_word_next[8*i +: 8] = wr_byte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pk_word_reg <= '0;
            pk_cnt_reg  <= '0;
        end
        else if (cmd.push)
        begin
            pk_word_reg <= '0;
            pk_cnt_reg  <= '0;
        end
        else if (wr_en)
        begin
            pk_word_reg <= pk_word_next;
            pk_cnt_reg  <= pk_cnt_reg + LANE_CW'(1);
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            out_bytes_reg <= pk_word_reg;
            out_cnt_reg   <= 4'(pk_cnt_reg);
            out_last_reg  <= cmd.push_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_bytes  = out_bytes_reg;
    assign byte_count = out_cnt_reg;
    assign last       = out_last_reg;

endmodule

// ===== rtl/core/lzss_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// lzss_stream_decoder
// byte-serial lzss decompressor with a 4096-byte circular history window
// ----------------------------------------------------------------------------
// One compressed byte is taken per transfer. Flag, length and high distance
// bytes are only taken; a literal is taken, then its group is handed to the
// output register. A match of n = length + 3 bytes is copied byte by byte and
// can be held by an output stall: every copied byte needs a window read step
// and then a window write step on the single history memory, and full groups
// of eight are handed over between bytes. Results carry up to eight bytes,
// first byte in the low lane, with tlast on the final group of each literal
// or match. The window reads as zero where it has never been written, so no
// clearing pass follows reset.
module lzss_stream_decoder
    import lzsd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // in_byte[7:0]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // out_bytes[63:0], byte_count[67:64], zero
    output logic                   m_tlast
);

    ctrl_cmd_t           cmd;
    dp_status_t          status;
    logic [8*LANES-1:0]  out_bytes;
    logic [3:0]          byte_count;

    lzsd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lzsd_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_byte    (s_tdata),
        .cmd        (cmd),
        .status     (status),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_bytes  (out_bytes),
        .byte_count (byte_count),
        .last       (m_tlast)
    );

    assign m_tdata = {{(OUT_TDATA_W - 8*LANES - 4){1'b0}}, byte_count, out_bytes};

    // a group is never loaded over a result that is still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> (!m_tvalid || m_tready))
        else $error("output group overwritten before transfer");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (byte_count != 4'd0 && byte_count <= 4'd8))
        else $error("byte count out of range");

    // only the closing group of a token may be short
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tlast) |-> (byte_count == 4'd8))
        else $error("short group without tlast");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled result changed");

endmodule
